[rtl/core/string_to_unsigned_parser_assert.svh]
// Assertion helpers for the string parser checker.
`ifndef STRING_TO_UNSIGNED_PARSER_ASSERT_SVH
`define STRING_TO_UNSIGNED_PARSER_ASSERT_SVH

// Clocked check, muted while reset is asserted.
`define STU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define STU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/core/stu_pkg.sv]
package stu_pkg;

  localparam int unsigned VALUE_BITS_DEF  = 64;
  localparam int unsigned OFFSET_BITS_DEF = 16;
  localparam int unsigned RADIX_W         = 6;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
  localparam logic [RADIX_W-1:0] BASE_DEC    = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_OCT    = 6'd8;
  localparam logic [RADIX_W-1:0] BASE_HEX    = 6'd16;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UX    = 8'h58;
  localparam logic [7:0] CHAR_UZ    = 8'h5a;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LX    = 8'h78;
  localparam logic [7:0] CHAR_LZ    = 8'h7a;

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_SIGNED,
    PH_ZERO_AUTO,
    PH_ZERO_HEX,
    PH_DIGITS,
    PH_STOPPED
  } stu_phase_e;

  // Per-string control state.
  typedef struct packed {
    stu_phase_e         phase;
    logic               neg;
    logic [RADIX_W-1:0] base;
  } stu_ctrl_t;

  typedef struct packed {
    logic               ok;
    logic [RADIX_W-1:0] val;
  } stu_digit_t;

  localparam stu_ctrl_t CTRL_RESET = '{phase: PH_SPACE, neg: 1'b0, base: '0};

  function automatic stu_digit_t digit_of(input logic [7:0] c);
    stu_digit_t d;
    d.ok  = 1'b0;
    d.val = '0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d.ok  = 1'b1;
      d.val = RADIX_W'(c - CHAR_ZERO);
    end else if (c >= CHAR_LA && c <= CHAR_LZ) begin
      d.ok  = 1'b1;
      d.val = RADIX_W'(c - (CHAR_LA - 8'd10));
    end else if (c >= CHAR_UA && c <= CHAR_UZ) begin
      d.ok  = 1'b1;
      d.val = RADIX_W'(c - (CHAR_UA - 8'd10));
    end
    return d;
  endfunction

endpackage

[rtl/core/stu_step.sv]
// One character of parsing: phase walk plus accumulator multiply-add.
module stu_step import stu_pkg::*; #(
  parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF,
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic [7:0]             char_i,
  input  logic [RADIX_W-1:0]     radix_i,
  input  stu_ctrl_t              ctrl_i,
  input  logic [VALUE_BITS-1:0]  acc_i,
  input  logic [OFFSET_BITS-1:0] idx_i,
  input  logic [OFFSET_BITS-1:0] stop_i,
  output stu_ctrl_t              ctrl_o,
  output logic [VALUE_BITS-1:0]  acc_o,
  output logic [OFFSET_BITS-1:0] idx_o,
  output logic [OFFSET_BITS-1:0] stop_o,
  output logic [VALUE_BITS-1:0]  value_o,
  output logic [OFFSET_BITS-1:0] offset_o
);

  stu_digit_t            dig;
  logic                  is_ws, is_sign, is_zero, is_x;
  logic                  adv, take, halt, done;
  logic [VALUE_BITS-1:0] prod;

  assign dig     = digit_of(char_i);
  assign is_ws   = (char_i == CHAR_SPACE) || (char_i >= CHAR_TAB && char_i <= CHAR_CR);
  assign is_sign = (char_i == CHAR_PLUS) || (char_i == CHAR_MINUS);
  assign is_zero = (char_i == CHAR_ZERO);
  assign is_x    = (char_i == CHAR_LX) || (char_i == CHAR_UX);

  // Next state: a character may fall through several phases in one step.
  always_comb begin
    ctrl_o = ctrl_i;
    done   = 1'b0;
    adv    = 1'b0;
    take   = 1'b0;
    halt   = 1'b0;

    if (ctrl_o.phase == PH_SPACE) begin
      if (is_ws) begin
        adv  = 1'b1;
        done = 1'b1;
      end else begin
        ctrl_o.phase = PH_SIGNED;
        if (is_sign) begin
          ctrl_o.neg = (char_i == CHAR_MINUS);
          adv        = 1'b1;
          done       = 1'b1;
        end
      end
    end

    if (!done && ctrl_o.phase == PH_SIGNED) begin
      if (radix_i == RADIX_AUTO) begin
        if (is_zero) begin
          ctrl_o.phase = PH_ZERO_AUTO;
          adv          = 1'b1;
          done         = 1'b1;
        end else begin
          ctrl_o.base  = BASE_DEC;
          ctrl_o.phase = PH_DIGITS;
        end
      end else if (radix_i == BASE_HEX && is_zero) begin
        ctrl_o.base  = BASE_HEX;
        ctrl_o.phase = PH_ZERO_HEX;
        adv          = 1'b1;
        done         = 1'b1;
      end else begin
        ctrl_o.base  = radix_i;
        ctrl_o.phase = PH_DIGITS;
      end
    end

    if (!done && ctrl_o.phase == PH_ZERO_AUTO) begin
      ctrl_o.phase = PH_DIGITS;
      if (is_x) begin
        ctrl_o.base = BASE_HEX;
        adv         = 1'b1;
        done        = 1'b1;
      end else begin
        ctrl_o.base = BASE_OCT;
      end
    end

    if (!done && ctrl_o.phase == PH_ZERO_HEX) begin
      ctrl_o.phase = PH_DIGITS;
      if (is_x) begin
        adv  = 1'b1;
        done = 1'b1;
      end
    end

    if (!done && ctrl_o.phase == PH_DIGITS) begin
      if (dig.ok && dig.val < ctrl_o.base) begin
        take = 1'b1;
      end else begin
        halt         = 1'b1;
        ctrl_o.phase = PH_STOPPED;
      end
    end
  end

  assign prod = acc_i * VALUE_BITS'(ctrl_o.base);

  // Datapath: accumulator, consumed count, stop offset.
  always_comb begin
    acc_o  = take ? prod + VALUE_BITS'(dig.val) : acc_i;
    idx_o  = ((adv || take) && idx_i != '1) ? idx_i + 1'b1 : idx_i;
    stop_o = halt ? idx_i : stop_i;
  end

  // Result as seen when the terminator arrives.
  assign value_o  = ctrl_i.neg ? VALUE_BITS'(0) - acc_i : acc_i;
  assign offset_o = (ctrl_i.phase == PH_STOPPED) ? stop_i : idx_i;

endmodule

[rtl/core/string_to_unsigned_parser.sv]
// String to unsigned integer parser. Characters arrive one word per cycle on
// the input channel unless it stalls; a code of 0 ends the string and yields
// one result word (value, stop_offset), while other characters yield nothing.
// Leading whitespace and one sign are skipped, then digits below the base are
// accumulated modulo 2^VALUE_BITS; the first rejected character freezes the
// value and the offset. A radix of 0 picks hex ("0x"), octal (leading 0) or
// decimal; a radix of 16 also skips "0x". Throughput is one character per
// cycle unless a terminator waits, set by the accumulator loop (one multiply
// by the 6-bit base plus an add between the state registers and themselves).
// A terminator passes the input register, then the result register. Only a
// terminator waits for the result register; other characters keep flowing
// while a result is stalled. Write the radix register only while no string is in flight.
module string_to_unsigned_parser import stu_pkg::*; #(
  parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF,
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // radix register
  input  logic                   cfg_we_i,
  input  logic [RADIX_W-1:0]     cfg_wdata_i,
  // character input
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             character_i,
  // result output
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [VALUE_BITS-1:0]  value_o,
  output logic [OFFSET_BITS-1:0] stop_offset_o
);

  logic [RADIX_W-1:0]     radix_q;

  // input register
  logic                   in_vld_q;
  logic [7:0]             char_q;

  // per-string state
  stu_ctrl_t              ctrl_q, ctrl_d;
  logic [VALUE_BITS-1:0]  acc_q, acc_d;
  logic [OFFSET_BITS-1:0] idx_q, idx_d;
  logic [OFFSET_BITS-1:0] stop_q, stop_d;

  // result register
  logic                   out_vld_q;
  logic [VALUE_BITS-1:0]  value_q;
  logic [OFFSET_BITS-1:0] offset_q;

  logic [VALUE_BITS-1:0]  res_value;
  logic [OFFSET_BITS-1:0] res_offset;

  logic term, go, accept, out_free;

  stu_step #(
    .VALUE_BITS (VALUE_BITS),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_step (
    .char_i  (char_q),
    .radix_i (radix_q),
    .ctrl_i  (ctrl_q),
    .acc_i   (acc_q),
    .idx_i   (idx_q),
    .stop_i  (stop_q),
    .ctrl_o  (ctrl_d),
    .acc_o   (acc_d),
    .idx_o   (idx_d),
    .stop_o  (stop_d),
    .value_o (res_value),
    .offset_o(res_offset)
  );

  // Result slot is free when empty or being drained this cycle.
  assign out_free = !out_vld_q || !out_stall_i;
  assign term     = (char_q == CHAR_NUL);
  // Held character moves on unless it is a terminator facing a full slot.
  assign go       = in_vld_q && (!term || out_free);
  assign in_stall_o = in_vld_q && !go;
  assign accept   = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (cfg_we_i) begin
      radix_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (go) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= character_i;
    end
  end

  // Terminator returns the string state to reset; the radix stays.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= CTRL_RESET;
      acc_q  <= '0;
      idx_q  <= '0;
      stop_q <= '0;
    end else if (go) begin
      if (term) begin
        ctrl_q <= CTRL_RESET;
        acc_q  <= '0;
        idx_q  <= '0;
        stop_q <= '0;
      end else begin
        ctrl_q <= ctrl_d;
        acc_q  <= acc_d;
        idx_q  <= idx_d;
        stop_q <= stop_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (go && term) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && term) begin
      value_q  <= res_value;
      offset_q <= res_offset;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign value_o       = value_q;
  assign stop_offset_o = offset_q;

endmodule

[rtl/core/stu_checker.sv]
`include "string_to_unsigned_parser_assert.svh"

module stu_checker import stu_pkg::*; #(
  parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF,
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic [7:0]             character_i,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [VALUE_BITS-1:0]  value_o,
  input logic [OFFSET_BITS-1:0] stop_offset_o
);

  // A stalled result word stays put.
  `STU_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result word dropped")
  `STU_ASSERT(a_out_stable, out_valid_o && out_stall_i |=> $stable(value_o) && $stable(stop_offset_o), "stalled result changed")

  // Input only backs up behind a stalled result.
  `STU_ASSERT_ALWAYS(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i, "input stalled with free result slot")

  // A fresh result follows a terminator taken at the input.
  `STU_ASSERT(a_result_src, $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && character_i == CHAR_NUL, 2), "result without terminator")

endmodule

bind string_to_unsigned_parser stu_checker #(
  .VALUE_BITS (VALUE_BITS),
  .OFFSET_BITS(OFFSET_BITS)
) u_stu_checker (.*);
